FILE: rtl/rafp_pkg.sv
// ----------------------------------------------------------------------------
// rafp_pkg
// shared constants, types and command/status structs of the roi align pool block
// ----------------------------------------------------------------------------
package rafp_pkg;

  localparam int MaxChannels = 16;
  localparam int MaxMapSize  = 64;
  localparam int MaxPooled   = 8;
  localparam int MaxSampling = 8;
  localparam int FracBits    = 20;

  localparam int ChW     = $clog2(MaxChannels);
  localparam int MapW    = $clog2(MaxMapSize);
  localparam int AddrW   = ChW + 2 * MapW;
  localparam int Depth   = MaxChannels * MaxMapSize * MaxMapSize;
  localparam int EdgeW   = 33;
  localparam int CoordW  = 34;
  localparam int DivNumW = 40;
  localparam int DivDenW = 8;

  localparam logic [2:0] RegScale   = 3'd0;
  localparam logic [2:0] RegPoolH   = 3'd1;
  localparam logic [2:0] RegPoolW   = 3'd2;
  localparam logic [2:0] RegSampl   = 3'd3;
  localparam logic [2:0] RegMapH    = 3'd4;
  localparam logic [2:0] RegMapW    = 3'd5;

  typedef struct packed {
    logic [16:0] img_scale;
    logic [3:0]  pooled_height;
    logic [3:0]  pooled_width;
    logic [3:0]  bin_samples;
    logic [6:0]  map_height;
    logic [6:0]  map_width;
  } cfg_t;

  typedef struct packed {
    logic       load_wr;
    logic       latch_roi;
    logic       scale_en;
    logic [1:0] scale_sel;
    logic       size_en;
    logic       cnt_init;
    logic       cnt_step;
    logic       coord_start;
    logic       coord_load;
    logic       coord_is_x;
    logic       acc_clr;
    logic       rd_en;
    logic [1:0] corner;
    logic       mul_en;
    logic       acc_en;
    logic       mag_en;
    logic       fin_start;
    logic       out_load;
    logic [2:0] ph;
    logic [2:0] pw;
    logic [2:0] iy;
    logic [2:0] ix;
  } cmd_t;

  typedef struct packed {
    logic       div_done;
    logic       oob;
    logic [3:0] ph_n;
    logic [3:0] pw_n;
    logic [3:0] s_h;
    logic [3:0] s_w;
  } sts_t;

endpackage

FILE: rtl/rafp_div.sv
// ----------------------------------------------------------------------------
// rafp_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module rafp_div import rafp_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [DivNumW-1:0] num_i,
  input  logic [DivDenW-1:0] den_i,
  output logic               done_o,
  output logic [DivNumW-1:0] quo_o
);

  localparam int CntW = $clog2(DivNumW + 1);

  logic [CntW-1:0]    cnt_q;
  logic [DivNumW-1:0] quo_q;
  logic [DivDenW:0]   rem_q;
  logic [DivDenW-1:0] den_q;
  logic [DivDenW:0]   rem_sh;
  logic               fits;

  assign rem_sh = {rem_q[DivDenW-1:0], quo_q[DivNumW-1]};
  assign fits   = rem_sh >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= CntW'(DivNumW);
    end else if (cnt_q != '0) begin
      cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (cnt_q != '0) begin
      rem_q <= fits ? rem_sh - {1'b0, den_q} : rem_sh;
      quo_q <= {quo_q[DivNumW-2:0], fits};
    end
  end

  assign done_o = (cnt_q == '0);
  assign quo_o  = quo_q;

endmodule

FILE: rtl/rafp_datapath.sv
// ----------------------------------------------------------------------------
// rafp_datapath
// feature store, region scaling, sample coordinates, bilinear accumulate, rounding
// ----------------------------------------------------------------------------
module rafp_datapath import rafp_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  cfg_t            cfg_i,
  input  cmd_t            cmd_i,
  input  logic [ChW-1:0]  channel_i,
  input  logic [MapW-1:0] row_i,
  input  logic [MapW-1:0] col_i,
  input  logic [15:0]     feat_value_i,
  input  logic [15:0]     roi_x1_i,
  input  logic [15:0]     roi_y1_i,
  input  logic [15:0]     roi_x2_i,
  input  logic [15:0]     roi_y2_i,
  output sts_t            sts_o,
  output logic [15:0]     out_value_o
);

  logic [15:0]      mem_q [Depth];
  logic [15:0]      rdata_q;
  logic [ChW-1:0]   ch_q;
  logic [15:0]      roi_q  [4];
  logic [EdgeW-1:0] edge_q [4];
  logic [EdgeW-1:0] size_w_q, size_h_q;
  logic [3:0]       s_h_q, s_w_q;
  logic [CoordW-1:0] y_q, x_q;
  logic [40:0]      w_q;
  logic signed [57:0] prod_q;
  logic signed [63:0] acc_q;
  logic [63:0]      mag_q;
  logic             neg_q;
  logic [15:0]      out_value_q;

  logic [3:0] ph_n, pw_n, sr;
  logic [6:0] mh, mw, hm1, wm1;

  always_comb begin
    ph_n = (cfg_i.pooled_height == '0) ? 4'd1 :
           (cfg_i.pooled_height > 4'(MaxPooled)) ? 4'(MaxPooled) : cfg_i.pooled_height;
    pw_n = (cfg_i.pooled_width == '0) ? 4'd1 :
           (cfg_i.pooled_width > 4'(MaxPooled)) ? 4'(MaxPooled) : cfg_i.pooled_width;
    sr   = (cfg_i.bin_samples > 4'(MaxSampling)) ? 4'(MaxSampling) : cfg_i.bin_samples;
    mh   = (cfg_i.map_height == '0) ? 7'd1 :
           (cfg_i.map_height > 7'(MaxMapSize)) ? 7'(MaxMapSize) : cfg_i.map_height;
    mw   = (cfg_i.map_width == '0) ? 7'd1 :
           (cfg_i.map_width > 7'(MaxMapSize)) ? 7'(MaxMapSize) : cfg_i.map_width;
    hm1  = mh - 7'd1;
    wm1  = mw - 7'd1;
  end

  // feature store
  logic [AddrW-1:0] rd_addr;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_wr) begin
      mem_q[{channel_i, row_i, col_i}] <= feat_value_i;
    end
    if (cmd_i.rd_en) begin
      rdata_q <= mem_q[rd_addr];
    end
  end

  // region edges and sizes
  logic [EdgeW-1:0] size_w_c, size_h_c;
  logic [EdgeW-1:0] one_q20;

  assign one_q20 = EdgeW'(1) << FracBits;

  always_comb begin
    size_w_c = (edge_q[2] > edge_q[0]) ? edge_q[2] - edge_q[0] : '0;
    size_h_c = (edge_q[3] > edge_q[1]) ? edge_q[3] - edge_q[1] : '0;
    if (size_w_c < one_q20) size_w_c = one_q20;
    if (size_h_c < one_q20) size_h_c = one_q20;
  end

  // adaptive sample counts
  logic [6:0] lim_h, lim_w;

  assign lim_h = 7'(s_h_q * ph_n);
  assign lim_w = 7'(s_w_q * pw_n);

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_roi) begin
      ch_q     <= channel_i;
      roi_q[0] <= roi_x1_i;
      roi_q[1] <= roi_y1_i;
      roi_q[2] <= roi_x2_i;
      roi_q[3] <= roi_y2_i;
    end
    if (cmd_i.scale_en) begin
      edge_q[cmd_i.scale_sel] <= EdgeW'(roi_q[cmd_i.scale_sel] * cfg_i.img_scale);
    end
    if (cmd_i.size_en) begin
      size_w_q <= size_w_c;
      size_h_q <= size_h_c;
    end
    if (cmd_i.cnt_init) begin
      s_h_q <= (sr == '0) ? 4'd1 : sr;
      s_w_q <= (sr == '0) ? 4'd1 : sr;
    end else if (cmd_i.cnt_step && sr == '0) begin
      if (s_h_q < 4'(MaxSampling) && size_h_q > EdgeW'({lim_h, 20'b0})) s_h_q <= s_h_q + 4'd1;
      if (s_w_q < 4'(MaxSampling) && size_w_q > EdgeW'({lim_w, 20'b0})) s_w_q <= s_w_q + 4'd1;
    end
  end

  // shared divider
  logic [3:0]         s_sel, p_sel;
  logic [2:0]         c_sel, i_sel;
  logic [5:0]         cs;
  logic [6:0]         k;
  logic [6:0]         ps;
  logic [6:0]         count;
  logic [EdgeW-1:0]   size_sel;
  logic [63:0]        rsum;
  logic [DivNumW-1:0] div_num;
  logic [DivDenW-1:0] div_den;
  logic               div_start, div_done;
  logic [DivNumW-1:0] quo;

  always_comb begin
    s_sel    = cmd_i.coord_is_x ? s_w_q : s_h_q;
    p_sel    = cmd_i.coord_is_x ? pw_n : ph_n;
    c_sel    = cmd_i.coord_is_x ? cmd_i.pw : cmd_i.ph;
    i_sel    = cmd_i.coord_is_x ? cmd_i.ix : cmd_i.iy;
    size_sel = cmd_i.coord_is_x ? size_w_q : size_h_q;
    cs       = 6'(c_sel * s_sel) + 6'(i_sel);
    k        = {cs, 1'b1};
    ps       = 7'(p_sel * s_sel);
    count    = 7'(s_h_q * s_w_q);
    rsum     = mag_q + (64'(count) << 39);
    if (cmd_i.fin_start) begin
      div_num = DivNumW'(rsum[63:40]);
      div_den = DivDenW'(count);
    end else begin
      div_num = DivNumW'(size_sel * k);
      div_den = {ps, 1'b0};
    end
  end

  assign div_start = cmd_i.coord_start | cmd_i.fin_start;

  rafp_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  // sample split
  logic [13:0] cell_y, cell_x;
  logic        edge_y, edge_x;
  logic [MapW-1:0] yl, yh, xl, xh;
  logic [19:0] ly, lx;
  logic [20:0] hy, hx, wy, wx;
  logic        oob;

  always_comb begin
    cell_y = y_q[CoordW-1:FracBits];
    cell_x = x_q[CoordW-1:FracBits];
    edge_y = cell_y >= 14'(hm1);
    edge_x = cell_x >= 14'(wm1);
    yl     = edge_y ? hm1[MapW-1:0] : cell_y[MapW-1:0];
    yh     = edge_y ? hm1[MapW-1:0] : cell_y[MapW-1:0] + 1'b1;
    xl     = edge_x ? wm1[MapW-1:0] : cell_x[MapW-1:0];
    xh     = edge_x ? wm1[MapW-1:0] : cell_x[MapW-1:0] + 1'b1;
    ly     = edge_y ? '0 : y_q[FracBits-1:0];
    lx     = edge_x ? '0 : x_q[FracBits-1:0];
    hy     = 21'(1) << FracBits;
    hy     = hy - {1'b0, ly};
    hx     = (21'(1) << FracBits) - {1'b0, lx};
    wy     = cmd_i.corner[1] ? {1'b0, ly} : hy;
    wx     = cmd_i.corner[0] ? {1'b0, lx} : hx;
    rd_addr = {ch_q, cmd_i.corner[1] ? yh : yl, cmd_i.corner[0] ? xh : xl};
    oob    = (y_q > CoordW'({mh, 20'b0})) || (x_q > CoordW'({mw, 20'b0}));
  end

  // coordinates, accumulate and rounding
  logic [15:0] res;

  always_comb begin
    if (neg_q) begin
      res = (quo > DivNumW'(32768)) ? 16'h8000 : 16'(-quo[15:0]);
    end else begin
      res = (quo > DivNumW'(32767)) ? 16'h7fff : quo[15:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.coord_load) begin
      if (cmd_i.coord_is_x) x_q <= {1'b0, edge_q[0]} + quo[CoordW-1:0];
      else                  y_q <= {1'b0, edge_q[1]} + quo[CoordW-1:0];
    end
    if (cmd_i.rd_en) begin
      w_q <= 41'(wy * wx);
    end
    if (cmd_i.mul_en) begin
      prod_q <= $signed(rdata_q) * $signed({1'b0, w_q});
    end
    if (cmd_i.acc_clr) begin
      acc_q <= '0;
    end else if (cmd_i.acc_en) begin
      acc_q <= acc_q + {{6{prod_q[57]}}, prod_q};
    end
    if (cmd_i.mag_en) begin
      neg_q <= acc_q[63];
      mag_q <= acc_q[63] ? 64'(-acc_q) : 64'(acc_q);
    end
    if (cmd_i.out_load) begin
      out_value_q <= res;
    end
  end

  assign sts_o.div_done = div_done;
  assign sts_o.oob      = oob;
  assign sts_o.ph_n     = ph_n;
  assign sts_o.pw_n     = pw_n;
  assign sts_o.s_h      = s_h_q;
  assign sts_o.s_w      = s_w_q;
  assign out_value_o    = out_value_q;

endmodule

FILE: rtl/rafp_ctrl.sv
// ----------------------------------------------------------------------------
// rafp_ctrl
// sequencer over setup, bins, sample rows, sample columns and corners
// ----------------------------------------------------------------------------
module rafp_ctrl import rafp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_valid_i,
  input  logic       s_query_i,
  output logic       s_ready_o,
  output logic       m_valid_o,
  input  logic       m_ready_i,
  output logic [2:0] bin_row_o,
  output logic [2:0] bin_col_o,
  output logic       last_o,
  input  sts_t       sts_i,
  output cmd_t       cmd_o
);

  typedef enum logic [4:0] {
    S_IDLE, S_SCALE, S_SIZE, S_CINIT, S_CSTEP, S_BIN, S_YSTART, S_YWAIT,
    S_XSTART, S_XWAIT, S_CHK, S_RD, S_MUL, S_ACC, S_NEXT, S_MAG, S_FSTART,
    S_FWAIT, S_OUT
  } state_e;

  state_e     state_q;
  logic [2:0] step_q, ph_q, pw_q, iy_q, ix_q;
  logic       m_valid_q, last_q;
  logic       ph_end, pw_end, iy_end, ix_end;

  assign ph_end = {1'b0, ph_q} == sts_i.ph_n - 4'd1;
  assign pw_end = {1'b0, pw_q} == sts_i.pw_n - 4'd1;
  assign iy_end = {1'b0, iy_q} == sts_i.s_h - 4'd1;
  assign ix_end = {1'b0, ix_q} == sts_i.s_w - 4'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      step_q    <= '0;
      ph_q      <= '0;
      pw_q      <= '0;
      iy_q      <= '0;
      ix_q      <= '0;
      m_valid_q <= 1'b0;
      last_q    <= 1'b0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (s_valid_i && s_query_i) begin
            step_q  <= '0;
            state_q <= S_SCALE;
          end
        end
        S_SCALE: begin
          step_q <= step_q + 3'd1;
          if (step_q == 3'd3) state_q <= S_SIZE;
        end
        S_SIZE:  state_q <= S_CINIT;
        S_CINIT: begin
          step_q  <= '0;
          state_q <= S_CSTEP;
        end
        S_CSTEP: begin
          step_q <= step_q + 3'd1;
          if (step_q == 3'd7) begin
            ph_q    <= '0;
            pw_q    <= '0;
            state_q <= S_BIN;
          end
        end
        S_BIN: begin
          iy_q    <= '0;
          state_q <= S_YSTART;
        end
        S_YSTART: state_q <= S_YWAIT;
        S_YWAIT: begin
          if (sts_i.div_done) begin
            ix_q    <= '0;
            state_q <= S_XSTART;
          end
        end
        S_XSTART: state_q <= S_XWAIT;
        S_XWAIT: begin
          if (sts_i.div_done) state_q <= S_CHK;
        end
        S_CHK: begin
          step_q  <= '0;
          state_q <= sts_i.oob ? S_NEXT : S_RD;
        end
        S_RD:  state_q <= S_MUL;
        S_MUL: state_q <= S_ACC;
        S_ACC: begin
          if (step_q == 3'd3) begin
            state_q <= S_NEXT;
          end else begin
            step_q  <= step_q + 3'd1;
            state_q <= S_RD;
          end
        end
        S_NEXT: begin
          if (!ix_end) begin
            ix_q    <= ix_q + 3'd1;
            state_q <= S_XSTART;
          end else if (!iy_end) begin
            iy_q    <= iy_q + 3'd1;
            state_q <= S_YSTART;
          end else begin
            state_q <= S_MAG;
          end
        end
        S_MAG:    state_q <= S_FSTART;
        S_FSTART: state_q <= S_FWAIT;
        S_FWAIT: begin
          if (sts_i.div_done) begin
            m_valid_q <= 1'b1;
            last_q    <= ph_end && pw_end;
            state_q   <= S_OUT;
          end
        end
        S_OUT: begin
          if (m_ready_i) begin
            m_valid_q <= 1'b0;
            if (last_q) begin
              state_q <= S_IDLE;
            end else begin
              if (pw_end) begin
                pw_q <= '0;
                ph_q <= ph_q + 3'd1;
              end else begin
                pw_q <= pw_q + 3'd1;
              end
              state_q <= S_BIN;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd_o             = '0;
    cmd_o.ph          = ph_q;
    cmd_o.pw          = pw_q;
    cmd_o.iy          = iy_q;
    cmd_o.ix          = ix_q;
    cmd_o.scale_sel   = step_q[1:0];
    cmd_o.corner      = step_q[1:0];
    cmd_o.load_wr     = (state_q == S_IDLE) && s_valid_i && !s_query_i;
    cmd_o.latch_roi   = (state_q == S_IDLE) && s_valid_i && s_query_i;
    cmd_o.scale_en    = (state_q == S_SCALE);
    cmd_o.size_en     = (state_q == S_SIZE);
    cmd_o.cnt_init    = (state_q == S_CINIT);
    cmd_o.cnt_step    = (state_q == S_CSTEP);
    cmd_o.acc_clr     = (state_q == S_BIN);
    cmd_o.coord_start = (state_q == S_YSTART) || (state_q == S_XSTART);
    cmd_o.coord_is_x  = (state_q == S_XSTART) || (state_q == S_XWAIT);
    cmd_o.coord_load  = ((state_q == S_YWAIT) || (state_q == S_XWAIT)) && sts_i.div_done;
    cmd_o.rd_en       = (state_q == S_RD);
    cmd_o.mul_en      = (state_q == S_MUL);
    cmd_o.acc_en      = (state_q == S_ACC);
    cmd_o.mag_en      = (state_q == S_MAG);
    cmd_o.fin_start   = (state_q == S_FSTART);
    cmd_o.out_load    = (state_q == S_FWAIT) && sts_i.div_done;
  end

  assign s_ready_o = (state_q == S_IDLE);
  assign m_valid_o = m_valid_q;
  assign bin_row_o = ph_q;
  assign bin_col_o = pw_q;
  assign last_o    = last_q;

  a_valid_in_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_q |-> state_q == S_OUT)
    else $error("result valid outside output state");

  a_last_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT && m_ready_i && last_q) |=> state_q == S_IDLE)
    else $error("query did not end after last bin");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_BIN) |-> (sts_i.s_h >= 4'd1 && sts_i.s_h <= 4'(MaxSampling) &&
                            sts_i.s_w >= 4'd1 && sts_i.s_w <= 4'(MaxSampling)))
    else $error("sample count out of range");

endmodule

FILE: rtl/roi_align_forward_pool_top.sv
// ----------------------------------------------------------------------------
// roi_align_forward_pool_top
// region align pooling over a stored feature map, one result per bin
// ----------------------------------------------------------------------------
// A load request writes one feature value. A query runs a setup phase, then
// works through each bin in turn, plus any wait for the result to be taken;
// the shared serial divider (one quotient bit per cycle, used for every sample
// coordinate and every bin average) and the single read port of the feature
// store (four reads per sample) set how long a query runs. One request is
// handled at a time.
module roi_align_forward_pool_top import rafp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // channel, row, col, feat_value, roi_x1, roi_y1, roi_x2, roi_y2
  input  logic [95:0] s_axis_tdata,
  // opcode
  input  logic        s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // out_value, bin_row, bin_col, zero pad
  output logic [23:0] m_axis_tdata,
  output logic        m_axis_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t cfg_q;
  cmd_t cmd;
  sts_t sts;
  logic [15:0] out_value;
  logic [2:0]  bin_row, bin_col;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.img_scale      <= 17'd4096;
      cfg_q.pooled_height  <= 4'd7;
      cfg_q.pooled_width   <= 4'd7;
      cfg_q.bin_samples    <= 4'd2;
      cfg_q.map_height     <= 7'd64;
      cfg_q.map_width      <= 7'd64;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[4:2])
        RegScale: cfg_q.img_scale      <= pwdata[16:0];
        RegPoolH: cfg_q.pooled_height  <= pwdata[3:0];
        RegPoolW: cfg_q.pooled_width   <= pwdata[3:0];
        RegSampl: cfg_q.bin_samples    <= pwdata[3:0];
        RegMapH:  cfg_q.map_height     <= pwdata[6:0];
        RegMapW:  cfg_q.map_width      <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      RegScale: prdata = 32'(cfg_q.img_scale);
      RegPoolH: prdata = 32'(cfg_q.pooled_height);
      RegPoolW: prdata = 32'(cfg_q.pooled_width);
      RegSampl: prdata = 32'(cfg_q.bin_samples);
      RegMapH:  prdata = 32'(cfg_q.map_height);
      RegMapW:  prdata = 32'(cfg_q.map_width);
      default:  prdata = '0;
    endcase
  end

  assign pready = 1'b1;

  rafp_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_query_i (s_axis_tuser),
    .s_ready_o (s_axis_tready),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .bin_row_o (bin_row),
    .bin_col_o (bin_col),
    .last_o    (m_axis_tlast),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  rafp_datapath u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .cmd_i        (cmd),
    .channel_i    (s_axis_tdata[3:0]),
    .row_i        (s_axis_tdata[9:4]),
    .col_i        (s_axis_tdata[15:10]),
    .feat_value_i (s_axis_tdata[31:16]),
    .roi_x1_i     (s_axis_tdata[47:32]),
    .roi_y1_i     (s_axis_tdata[63:48]),
    .roi_x2_i     (s_axis_tdata[79:64]),
    .roi_y2_i     (s_axis_tdata[95:80]),
    .sts_o        (sts),
    .out_value_o  (out_value)
  );

  assign m_axis_tdata = {2'b00, bin_col, bin_row, out_value};

endmodule
